>>> rtl/core/matrix2x2_arithmetic_unit_macros.svh
// matrix2x2_arithmetic_unit_macros.svh: assertion macros for the 2x2 matrix unit
// needs nothing; taken in by the files that assert
`ifndef MATRIX2X2_ARITHMETIC_UNIT_MACROS_SVH
`define MATRIX2X2_ARITHMETIC_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define M2X_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define M2X_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/m2x_pkg.sv
// m2x_pkg.sv: types, opcodes and helpers of the 2x2 matrix unit
// depends on nothing; used by every module of the unit
package m2x_pkg;

    localparam int FRAC_BITS = 16;
    // quotient bits produced by the divider
    localparam int QB = 32;
    // determinant magnitude width
    localparam int DW = 64;
    // dividend width, covers the largest fraction width of 24
    localparam int NW = 80;
    // divider compare width
    localparam int CW = DW + QB;

    localparam logic [31:0] THRESH_RESET = 32'd4295;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SUB    = 3'd1;
    localparam logic [2:0] OP_MUL    = 3'd2;
    localparam logic [2:0] OP_SCALE  = 3'd3;
    localparam logic [2:0] OP_MATVEC = 3'd4;
    localparam logic [2:0] OP_TRANSP = 3'd5;
    localparam logic [2:0] OP_DET    = 3'd6;
    localparam logic [2:0] OP_INV    = 3'd7;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_row0_col0;
        logic signed [31:0] a_row0_col1;
        logic signed [31:0] a_row1_col0;
        logic signed [31:0] a_row1_col1;
        logic signed [31:0] b_row0_col0;
        logic signed [31:0] b_row0_col1;
        logic signed [31:0] b_row1_col0;
        logic signed [31:0] b_row1_col1;
        logic signed [31:0] scale_factor;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] r_row0_col0;
        logic signed [31:0] r_row0_col1;
        logic signed [31:0] r_row1_col0;
        logic signed [31:0] r_row1_col1;
        logic               singular;
        logic               overflow;
    } t_out;

    // beat carried down the divider chain
    typedef struct packed {
        logic                   inv_go;
        logic [3:0]             neg;
        logic [3:0]             big;
        logic [DW-1:0]          dmag;
        logic [3:0][NW-1:0]     rem;
        logic [3:0][QB-1:0]     quo;
        t_out                   res;
    } t_div_beat;

    // saturate to 32 bits, returns {overflow, value}
    function automatic logic [32:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -65'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

endpackage

>>> rtl/core/m2x_front.sv
// m2x_front.sv: multiply, sum, round and divider setup stages (four registers)
// depends on m2x_pkg
module m2x_front #(
    parameter int FRAC_BITS = m2x_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  m2x_pkg::t_in       i_data,
    input  logic [31:0]        i_threshold,
    output logic               o_valid,
    output m2x_pkg::t_div_beat o_beat
);

    // stage 1: operand select and products
    logic [7:0][31:0]  n1_x, n1_y;
    logic              n1_sub;
    logic [3:0][31:0]  w_a, w_b;
    logic [3:0][32:0]  n1_as;

    logic              r1_valid;
    logic [2:0]        r1_op;
    logic [3:0][31:0]  r1_a;
    logic              r1_sub;
    logic [7:0][63:0]  r1_p;
    logic [3:0][32:0]  r1_as;

    assign w_a = {i_data.a_row1_col1, i_data.a_row1_col0, i_data.a_row0_col1, i_data.a_row0_col0};
    assign w_b = {i_data.b_row1_col1, i_data.b_row1_col0, i_data.b_row0_col1, i_data.b_row0_col0};

    always_comb begin
        n1_x   = '0;
        n1_y   = '0;
        n1_sub = 1'b0;
        case (i_data.opcode)
            m2x_pkg::OP_MUL: begin
                n1_x[0] = w_a[0]; n1_y[0] = w_b[0];
                n1_x[1] = w_a[1]; n1_y[1] = w_b[2];
                n1_x[2] = w_a[0]; n1_y[2] = w_b[1];
                n1_x[3] = w_a[1]; n1_y[3] = w_b[3];
                n1_x[4] = w_a[2]; n1_y[4] = w_b[0];
                n1_x[5] = w_a[3]; n1_y[5] = w_b[2];
                n1_x[6] = w_a[2]; n1_y[6] = w_b[1];
                n1_x[7] = w_a[3]; n1_y[7] = w_b[3];
            end
            m2x_pkg::OP_SCALE: begin
                n1_x[0] = w_a[0]; n1_y[0] = i_data.scale_factor;
                n1_x[2] = w_a[1]; n1_y[2] = i_data.scale_factor;
                n1_x[4] = w_a[2]; n1_y[4] = i_data.scale_factor;
                n1_x[6] = w_a[3]; n1_y[6] = i_data.scale_factor;
            end
            m2x_pkg::OP_MATVEC: begin
                n1_x[0] = w_a[0]; n1_y[0] = i_data.vec_x;
                n1_x[1] = w_a[1]; n1_y[1] = i_data.vec_y;
                n1_x[4] = w_a[2]; n1_y[4] = i_data.vec_x;
                n1_x[5] = w_a[3]; n1_y[5] = i_data.vec_y;
            end
            m2x_pkg::OP_DET, m2x_pkg::OP_INV: begin
                n1_x[0] = w_a[0]; n1_y[0] = w_a[3];
                n1_x[1] = w_a[1]; n1_y[1] = w_a[2];
                n1_sub  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // elementwise add or subtract, exact in 33 bits
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (i_data.opcode == m2x_pkg::OP_SUB) begin
                n1_as[k] = {w_a[k][31], w_a[k]} - {w_b[k][31], w_b[k]};
            end else begin
                n1_as[k] = {w_a[k][31], w_a[k]} + {w_b[k][31], w_b[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op  <= i_data.opcode;
            r1_a   <= w_a;
            r1_sub <= n1_sub;
            r1_as  <= n1_as;
            for (int k = 0; k < 8; k++) begin
                r1_p[k] <= $signed(n1_x[k]) * $signed(n1_y[k]);
            end
        end
    end

    // stage 2: exact sums of product pairs and saturated add or subtract results
    logic              r2_valid;
    logic [2:0]        r2_op;
    logic [3:0][31:0]  r2_a;
    logic [3:0][64:0]  r2_s;
    logic [3:0][32:0]  r2_as;
    logic [3:0][64:0]  n2_s;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r1_sub) begin
                n2_s[k] = {r1_p[2*k][63], r1_p[2*k]} - {r1_p[2*k+1][63], r1_p[2*k+1]};
            end else begin
                n2_s[k] = {r1_p[2*k][63], r1_p[2*k]} + {r1_p[2*k+1][63], r1_p[2*k+1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_op <= r1_op;
            r2_a  <= r1_a;
            r2_s  <= n2_s;
            for (int k = 0; k < 4; k++) begin
                r2_as[k] <= m2x_pkg::sat32($signed({{32{r1_as[k][32]}}, r1_as[k]}));
            end
        end
    end

    // stage 3: floor, saturate, determinant magnitude and singular test
    logic              r3_valid;
    logic [2:0]        r3_op;
    logic [3:0][31:0]  r3_a;
    logic [3:0][32:0]  r3_el;
    logic [63:0]       r3_dmag;
    logic              r3_dneg;
    logic              r3_sing;
    logic [3:0][32:0]  n3_el;
    logic [63:0]       n3_dmag;
    logic signed [64:0] w_sh [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_sh[k] = $signed(r2_s[k]) >>> FRAC_BITS;
            if (r2_op == m2x_pkg::OP_ADD || r2_op == m2x_pkg::OP_SUB) begin
                n3_el[k] = r2_as[k];
            end else begin
                n3_el[k] = m2x_pkg::sat32(w_sh[k]);
            end
        end
        n3_dmag = r2_s[0][64] ? (~r2_s[0][63:0] + 64'd1) : r2_s[0][63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_op   <= r2_op;
            r3_a    <= r2_a;
            r3_el   <= n3_el;
            r3_dmag <= n3_dmag;
            r3_dneg <= r2_s[0][64];
            r3_sing <= (n3_dmag == '0) || (n3_dmag < {32'd0, i_threshold});
        end
    end

    // stage 4: result pick and dividend setup for the inverse
    logic                r4_valid;
    m2x_pkg::t_div_beat  r4_beat;
    m2x_pkg::t_div_beat  n4_beat;
    logic [3:0][31:0]    w_num;
    logic [3:0]          w_nneg;
    logic [3:0][31:0]    w_nmag;
    logic [3:0][m2x_pkg::NW-1:0] w_n;

    always_comb begin
        // adjugate lanes: a11, -a01, -a10, a00
        w_num[0]  = r3_a[3];
        w_num[1]  = r3_a[1];
        w_num[2]  = r3_a[2];
        w_num[3]  = r3_a[0];
        w_nneg[0] = r3_a[3][31];
        w_nneg[1] = !r3_a[1][31] && (r3_a[1] != '0);
        w_nneg[2] = !r3_a[2][31] && (r3_a[2] != '0);
        w_nneg[3] = r3_a[0][31];

        n4_beat      = '0;
        n4_beat.dmag = r3_dmag;
        for (int k = 0; k < 4; k++) begin
            w_nmag[k]       = w_num[k][31] ? (~w_num[k] + 32'd1) : w_num[k];
            w_n[k]          = m2x_pkg::NW'(w_nmag[k]) << (2 * FRAC_BITS);
            n4_beat.rem[k]  = w_n[k];
            n4_beat.neg[k]  = w_nneg[k] ^ r3_dneg;
            n4_beat.big[k]  = m2x_pkg::CW'(w_n[k]) >= (m2x_pkg::CW'(r3_dmag) << m2x_pkg::QB);
        end

        case (r3_op)
            m2x_pkg::OP_TRANSP: begin
                n4_beat.res.r_row0_col0 = r3_a[0];
                n4_beat.res.r_row0_col1 = r3_a[2];
                n4_beat.res.r_row1_col0 = r3_a[1];
                n4_beat.res.r_row1_col1 = r3_a[3];
            end
            m2x_pkg::OP_INV: begin
                if (r3_sing) begin
                    n4_beat.res.r_row0_col0 = r3_a[0];
                    n4_beat.res.r_row0_col1 = r3_a[1];
                    n4_beat.res.r_row1_col0 = r3_a[2];
                    n4_beat.res.r_row1_col1 = r3_a[3];
                    n4_beat.res.singular    = 1'b1;
                end else begin
                    n4_beat.inv_go = 1'b1;
                end
            end
            default: begin
                n4_beat.res.r_row0_col0 = r3_el[0][31:0];
                n4_beat.res.r_row0_col1 = r3_el[1][31:0];
                n4_beat.res.r_row1_col0 = r3_el[2][31:0];
                n4_beat.res.r_row1_col1 = r3_el[3][31:0];
                n4_beat.res.overflow    = r3_el[0][32] | r3_el[1][32]
                                        | r3_el[2][32] | r3_el[3][32];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_beat <= n4_beat;
        end
    end

    assign o_valid = r4_valid;
    assign o_beat  = r4_beat;

endmodule

>>> rtl/core/m2x_div_step.sv
// m2x_div_step.sv: one restoring divide stage, one quotient bit per lane
// depends on m2x_pkg
module m2x_div_step #(
    parameter int BIT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  m2x_pkg::t_div_beat i_beat,
    output logic               o_valid,
    output m2x_pkg::t_div_beat o_beat
);

    logic                       r_valid;
    m2x_pkg::t_div_beat         r_beat;
    m2x_pkg::t_div_beat         n_beat;
    logic [m2x_pkg::CW-1:0]     w_dsh;
    logic [3:0]                 w_ge;

    // compare each partial remainder with the shifted divisor
    always_comb begin
        n_beat = i_beat;
        w_dsh  = m2x_pkg::CW'(i_beat.dmag) << BIT;
        for (int k = 0; k < 4; k++) begin
            w_ge[k] = m2x_pkg::CW'(i_beat.rem[k]) >= w_dsh;
            if (w_ge[k]) begin
                n_beat.rem[k] = i_beat.rem[k] - w_dsh[m2x_pkg::NW-1:0];
            end
            n_beat.quo[k][BIT] = w_ge[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

>>> rtl/core/matrix2x2_arithmetic_unit.sv
// Fully pipelined 2x2 matrix unit: one beat in and one beat out per cycle (4 front
// stages for multiply, sum, round and divider setup, 32 restoring divide stages that
// each settle one quotient bit of the inverse, 1 output register). Every opcode
// takes the same path, so results leave in input order. A stall on the output
// freezes the whole pipeline once the output register holds a beat, and o_in_stall
// then follows i_out_stall. Users write the singular threshold through i_cfg_wr_en /
// i_cfg_wr_data only while the pipeline is empty; the block does not enforce it.
// depends on m2x_pkg, m2x_front, m2x_div_step and the assertion macro header
`include "matrix2x2_arithmetic_unit_macros.svh"

module matrix2x2_arithmetic_unit #(
    parameter int FRAC_BITS = m2x_pkg::FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  m2x_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output m2x_pkg::t_out o_out_data,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data
);

    logic                r_singular_threshold;
    logic [31:0]         r_threshold;
    logic                w_en;
    logic [m2x_pkg::QB:0] w_vld;
    m2x_pkg::t_div_beat  w_beat [m2x_pkg::QB+1];
    logic                r_out_valid;
    m2x_pkg::t_out       r_out_data;
    m2x_pkg::t_out       n_out_data;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold          <= m2x_pkg::THRESH_RESET;
            r_singular_threshold <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_threshold          <= i_cfg_wr_data;
            r_singular_threshold <= 1'b1;
        end
    end

    // pipeline moves unless a held result is stalled
    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;

    m2x_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_in_valid),
        .i_data      (i_in_data),
        .i_threshold (r_threshold),
        .o_valid     (w_vld[0]),
        .o_beat      (w_beat[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar g = 0; g < m2x_pkg::QB; g++) begin : g_div
        m2x_div_step #(
            .BIT (m2x_pkg::QB - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[g]),
            .i_beat  (w_beat[g]),
            .o_valid (w_vld[g+1]),
            .o_beat  (w_beat[g+1])
        );
    end

    // sign, remainder correction and saturation of the quotients
    m2x_pkg::t_div_beat w_last;
    logic [3:0][31:0]   w_q;
    logic [3:0]         w_qov;
    logic [3:0][32:0]   w_q33;

    assign w_last = w_beat[m2x_pkg::QB];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_q33[k] = {1'b0, w_last.quo[k]} + {32'd0, (w_last.rem[k] != '0)};
            if (w_last.neg[k]) begin
                if (w_last.big[k] || w_q33[k] > 33'h0_8000_0000) begin
                    w_q[k]   = 32'h8000_0000;
                    w_qov[k] = 1'b1;
                end else begin
                    w_q[k]   = ~w_q33[k][31:0] + 32'd1;
                    w_qov[k] = 1'b0;
                end
            end else begin
                if (w_last.big[k] || w_last.quo[k] > 32'h7FFF_FFFF) begin
                    w_q[k]   = 32'h7FFF_FFFF;
                    w_qov[k] = 1'b1;
                end else begin
                    w_q[k]   = w_last.quo[k];
                    w_qov[k] = 1'b0;
                end
            end
        end
        n_out_data = w_last.res;
        if (w_last.inv_go) begin
            n_out_data.r_row0_col0 = w_q[0];
            n_out_data.r_row0_col1 = w_q[1];
            n_out_data.r_row1_col0 = w_q[2];
            n_out_data.r_row1_col1 = w_q[3];
            n_out_data.overflow    = |w_qov;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_vld[m2x_pkg::QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a refused inverse never reports saturation
    `M2X_ASSERT_NOW(a_sing_no_ov, i_clk, i_rst_n, r_out_valid && r_out_data.singular, !r_out_data.overflow, "singular beat with overflow")
    // output only fills from the last divide stage
    `M2X_ASSERT_NEXT(a_out_from_chain, i_clk, i_rst_n, !r_out_valid && !w_vld[m2x_pkg::QB], !r_out_valid, "output valid without a beat in the chain")
    // a frozen pipeline keeps its last divide stage
    `M2X_ASSERT_NEXT(a_chain_frozen, i_clk, i_rst_n, !w_en, $stable(w_vld[m2x_pkg::QB]), "divide chain moved while stalled")
    // a written threshold is the written data
    `M2X_ASSERT_NEXT(a_cfg_taken, i_clk, i_rst_n, i_cfg_wr_en, r_singular_threshold && r_threshold == $past(i_cfg_wr_data), "threshold write lost")

endmodule

>>> tb/sv/tb.sv
// tb.sv: self-checking testbench for the 2x2 matrix arithmetic unit
// drives random and directed matrix beats, predicts each result and compares in order
// depends on m2x_pkg and matrix2x2_arithmetic_unit
`timescale 1ns / 100ps

module tb;

    localparam int FB = 16;
    localparam int LATENCY = 37;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    m2x_pkg::t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    m2x_pkg::t_out o_out_data;
    logic i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    logic [31:0] threshold;
    m2x_pkg::t_out expected_q[$];
    int errors;
    int cycles;
    bit stall_enable;

    matrix2x2_arithmetic_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // saturate an exact value to 32 bits
    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ov);
        if (v > 128'sd2147483647) begin
            ov = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            ov = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // floor division of exact values, arithmetic shift floors
    function automatic logic [31:0] floor_fix(input logic signed [127:0] v, inout logic ov);
        logic signed [127:0] f;
        f = v >>> FB;
        return clamp32(f, ov);
    endfunction

    function automatic logic [31:0] floor_div(input logic signed [127:0] num,
                                              input logic signed [127:0] den, inout logic ov);
        logic signed [127:0] n;
        logic signed [127:0] q;
        n = num <<< (2 * FB);
        q = n / den;
        if ((n % den != 0) && ((n < 0) != (den < 0))) q = q - 1;
        return clamp32(q, ov);
    endfunction

    function automatic m2x_pkg::t_out predict_matrix(input m2x_pkg::t_in x);
        m2x_pkg::t_out r;
        logic ov;
        logic signed [127:0] a00, a01, a10, a11, b00, b01, b10, b11, s, vx, vy, det, dmag;
        ov = 1'b0;
        r = '0;
        a00 = x.a_row0_col0; a01 = x.a_row0_col1; a10 = x.a_row1_col0; a11 = x.a_row1_col1;
        b00 = x.b_row0_col0; b01 = x.b_row0_col1; b10 = x.b_row1_col0; b11 = x.b_row1_col1;
        s = x.scale_factor; vx = x.vec_x; vy = x.vec_y;
        det = a00 * a11 - a01 * a10;
        dmag = det < 0 ? -det : det;
        case (x.opcode)
            m2x_pkg::OP_ADD: begin
                r.r_row0_col0 = clamp32(a00 + b00, ov);
                r.r_row0_col1 = clamp32(a01 + b01, ov);
                r.r_row1_col0 = clamp32(a10 + b10, ov);
                r.r_row1_col1 = clamp32(a11 + b11, ov);
            end
            m2x_pkg::OP_SUB: begin
                r.r_row0_col0 = clamp32(a00 - b00, ov);
                r.r_row0_col1 = clamp32(a01 - b01, ov);
                r.r_row1_col0 = clamp32(a10 - b10, ov);
                r.r_row1_col1 = clamp32(a11 - b11, ov);
            end
            m2x_pkg::OP_MUL: begin
                r.r_row0_col0 = floor_fix(a00 * b00 + a01 * b10, ov);
                r.r_row0_col1 = floor_fix(a00 * b01 + a01 * b11, ov);
                r.r_row1_col0 = floor_fix(a10 * b00 + a11 * b10, ov);
                r.r_row1_col1 = floor_fix(a10 * b01 + a11 * b11, ov);
            end
            m2x_pkg::OP_SCALE: begin
                r.r_row0_col0 = floor_fix(a00 * s, ov);
                r.r_row0_col1 = floor_fix(a01 * s, ov);
                r.r_row1_col0 = floor_fix(a10 * s, ov);
                r.r_row1_col1 = floor_fix(a11 * s, ov);
            end
            m2x_pkg::OP_MATVEC: begin
                r.r_row0_col0 = floor_fix(a00 * vx + a01 * vy, ov);
                r.r_row1_col0 = floor_fix(a10 * vx + a11 * vy, ov);
            end
            m2x_pkg::OP_TRANSP: begin
                r.r_row0_col0 = x.a_row0_col0;
                r.r_row0_col1 = x.a_row1_col0;
                r.r_row1_col0 = x.a_row0_col1;
                r.r_row1_col1 = x.a_row1_col1;
            end
            m2x_pkg::OP_DET: r.r_row0_col0 = floor_fix(det, ov);
            default: begin
                // refused inverse hands back A untouched
                if (dmag == 0 || dmag < {96'd0, threshold}) begin
                    r.singular = 1'b1;
                    r.r_row0_col0 = x.a_row0_col0;
                    r.r_row0_col1 = x.a_row0_col1;
                    r.r_row1_col0 = x.a_row1_col0;
                    r.r_row1_col1 = x.a_row1_col1;
                end else begin
                    r.r_row0_col0 = floor_div(a11, det, ov);
                    r.r_row0_col1 = floor_div(-a01, det, ov);
                    r.r_row1_col0 = floor_div(-a10, det, ov);
                    r.r_row1_col1 = floor_div(a00, det, ov);
                end
            end
        endcase
        r.overflow = ov;
        return r;
    endfunction

    // cycle counter and receiver stall pattern
    always @(negedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("Mismatches found");
            $finish;
        end
        if (!stall_enable) i_out_stall <= 1'b0;
        else if ((cycles / 64) % 3 == 0) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 99) < 40);
    end

    // result checker
    always @(posedge i_clk) begin
        m2x_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected beat actual=%h", $time, o_out_data);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (want.r_row0_col0 !== o_out_data.r_row0_col0 ||
                    want.r_row0_col1 !== o_out_data.r_row0_col1 ||
                    want.r_row1_col0 !== o_out_data.r_row1_col0 ||
                    want.r_row1_col1 !== o_out_data.r_row1_col1 ||
                    want.singular !== o_out_data.singular ||
                    want.overflow !== o_out_data.overflow) begin
                    $display("%0t mismatch expected=%h actual=%h", $time, want, o_out_data);
                    errors++;
                end
            end
        end
    end

    // send one beat, hold until accepted; valid stays up for a following beat
    task automatic send_matrix(input m2x_pkg::t_in x);
        i_in_data <= x;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(predict_matrix(x));
        @(negedge i_clk);
    endtask

    // drop valid for a number of cycles
    task automatic idle(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [31:0] v);
        drain_pipeline();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        threshold = v;
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
            2: return 32'($signed($urandom_range(0, 8))) <<< ($urandom_range(10, 20));
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic m2x_pkg::t_in rand_item(input logic [2:0] op);
        m2x_pkg::t_in x;
        x.opcode = op;
        x.a_row0_col0 = rand_elem(); x.a_row0_col1 = rand_elem();
        x.a_row1_col0 = rand_elem(); x.a_row1_col1 = rand_elem();
        x.b_row0_col0 = rand_elem(); x.b_row0_col1 = rand_elem();
        x.b_row1_col0 = rand_elem(); x.b_row1_col1 = rand_elem();
        x.scale_factor = rand_elem(); x.vec_x = rand_elem(); x.vec_y = rand_elem();
        // near singular inverses
        if (op == m2x_pkg::OP_INV && $urandom_range(0, 3) == 0) begin
            x.a_row1_col0 = x.a_row0_col0;
            x.a_row1_col1 = x.a_row0_col1 + 32'($urandom_range(0, 3));
        end
        return x;
    endfunction

    // extremes, every opcode, zero and tiny determinants
    task automatic test_directed();
        m2x_pkg::t_in x;
        for (int op = 0; op < 8; op++) begin
            x = '{default: 32'h7FFF_FFFF, opcode: op[2:0]};
            send_matrix(x);
            x = '{default: 32'h8000_0000, opcode: op[2:0]};
            send_matrix(x);
        end
        x = '{default: 32'h0, opcode: m2x_pkg::OP_INV};
        send_matrix(x);
        x.a_row0_col0 = 32'h0001_0000; x.a_row1_col1 = 32'h0001_0000;
        send_matrix(x);
        x.a_row0_col0 = 32'd1; x.a_row1_col1 = 32'd1;
        send_matrix(x);
        x.a_row0_col0 = 32'd65; x.a_row1_col1 = 32'd66;
        send_matrix(x);
        x.a_row0_col0 = 32'h8000_0000; x.a_row1_col1 = 32'h8000_0000;
        x.a_row0_col1 = 32'h8000_0000; x.a_row1_col0 = 32'h7FFF_FFFF;
        send_matrix(x);
        x = '{default: 32'hFFFF_FFFF, opcode: m2x_pkg::OP_DET};
        x.a_row0_col0 = 32'h1; x.a_row1_col1 = 32'h1;
        send_matrix(x);
    endtask

    // bursts of random beats with random gaps
    task automatic test_random(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && sent < count; k++, sent++)
                send_matrix(rand_item(3'($urandom_range(0, 7))));
            if ($urandom_range(0, 1)) idle($urandom_range(1, 8));
        end
    endtask

    task automatic test_thresholds();
        m2x_pkg::t_in x;
        logic [31:0] vals[3];
        vals = '{32'd0, 32'hFFFF_FFFF, 32'd70000};
        foreach (vals[i]) begin
            write_threshold(vals[i]);
            x = '{default: 32'h0, opcode: m2x_pkg::OP_INV};
            x.a_row0_col0 = 32'd1; x.a_row1_col1 = 32'd1;
            send_matrix(x);
            x.a_row0_col0 = 32'h0001_0000; x.a_row1_col1 = 32'h0001_0000;
            send_matrix(x);
            x.a_row0_col0 = 32'h0; x.a_row1_col1 = 32'h0;
            send_matrix(x);
            for (int k = 0; k < 40; k++) send_matrix(rand_item(m2x_pkg::OP_INV));
        end
        write_threshold(m2x_pkg::THRESH_RESET);
    endtask

    initial begin
        stall_enable = 1'b0;
        threshold = m2x_pkg::THRESH_RESET;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        stall_enable = 1'b1;
        test_random(500);
        // hold off until the pipeline empties
        drain_pipeline();
        test_thresholds();
        test_random(580);
        drain_pipeline();
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
